// ===== sv/sra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sra_pkg;

    // Field widths
    localparam int SCORE_W = 16;
    localparam int RANK_W  = 6;

    // Largest rank that fits the rank field
    localparam logic [RANK_W-1:0] RANK_MAX = 6'd63;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_PIVOT = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_SWEEP = 4'b1000
    } state_t;

    // Control from the sequencer to the rank engine
    typedef struct packed {
        logic load_pivot;
        logic accumulate;
    } sra_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/sra_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/sra_rank_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sra_rank_engine import sra_pkg::*; #(
    parameter int CW = 6
) (
    input  wire logic               clk,
    input  wire sra_ctrl_t          ctrl,
    input  wire logic [SCORE_W-1:0] rd_data,
    output logic      [RANK_W-1:0]  rank
);

    localparam int EW = (CW + 1 > RANK_W + 1) ? CW + 1 : RANK_W + 1;

    logic [SCORE_W-1:0] pivot_reg;
    logic [CW-1:0]      greater_reg;
    logic               gt;
    logic [CW-1:0]      greater_sum;
    logic [EW-1:0]      rank_ext;

    // Compare the swept score against the pivot and count
    assign gt          = (rd_data > pivot_reg);
    assign greater_sum = greater_reg + CW'(gt);

    // Rank is one past the count, saturated to the field
    assign rank_ext = EW'(greater_sum) + EW'(1);
    assign rank     = (rank_ext > EW'(RANK_MAX)) ? RANK_MAX : rank_ext[RANK_W-1:0];

    // Latch the pivot and clear the count, or advance the count
    always_ff @(posedge clk)
    begin
        if (ctrl.load_pivot)
        begin
            pivot_reg   <= rd_data;
            greater_reg <= '0;
        end
        else if (ctrl.accumulate)
        begin
            greater_reg <= greater_sum;
        end
    end

endmodule

`default_nettype wire

// ===== sv/score_rank_assigner.sv =====
// Channel   Handshake           Payload              Direction
// -------   -----------------   ------------------   ---------
// input     start && !busy      score, last_score    in
// result    valid (one cycle)   rank, last_rank      out
//
// Loading takes one score per cycle while busy is low. After the set
// closes (last_score, or MAX_ITEMS scores held), the rank pass handles n
// scores: each rank fetches its pivot, then sweeps all n stored scores
// through the single read port of the score memory. busy is high for the
// whole pass. Reset clears the sequencer and the fill count; the score
// memory is not cleared. The receiver cannot stall: each rank is shown on
// valid for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module score_rank_assigner import sra_pkg::*; #(
    parameter int MAX_ITEMS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [SCORE_W-1:0] score,
    input  wire logic               last_score,
    output logic                    valid,
    output logic      [RANK_W-1:0]  rank,
    output logic                    last_rank
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [AW-1:0]      rd_addr;
    logic [SCORE_W-1:0] rd_data;
    logic               accept;
    logic               close;
    logic               last_k;
    logic               last_i;
    sra_ctrl_t          ctrl;

    assign busy   = (state_reg != ST_LOAD);
    assign accept = start && (state_reg == ST_LOAD);
    assign close  = accept && (last_score || (cnt_reg + CW'(1) == CW'(MAX_ITEMS)));
    assign last_k = (CW'(k_reg) == cnt_reg - CW'(1));
    assign last_i = (CW'(idx_reg) == cnt_reg - CW'(1));

    // Score store
    sra_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (score),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Compare and count unit
    sra_rank_engine #(
        .CW (CW)
    ) u_engine (
        .clk     (clk),
        .ctrl    (ctrl),
        .rd_data (rd_data),
        .rank    (rank)
    );

    // Sequence the load and the rank pass
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        rd_addr         = k_reg;
        ctrl.load_pivot = 1'b0;
        ctrl.accumulate = 1'b0;
        valid           = 1'b0;
        last_rank       = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (close)
                begin
                    idx_next   = '0;
                    state_next = ST_PIVOT;
                end
            end
            ST_PIVOT:
            begin
                rd_addr    = idx_reg;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                ctrl.load_pivot = 1'b1;
                rd_addr         = '0;
                k_next          = '0;
                state_next      = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                ctrl.accumulate = 1'b1;
                if (last_k)
                begin
                    valid     = 1'b1;
                    last_rank = last_i;
                    rd_addr   = idx_reg + AW'(1);
                    if (last_i)
                    begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_FETCH;
                    end
                end
                else
                begin
                    k_next  = k_reg + AW'(1);
                    rd_addr = k_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sra_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sra_checker import sra_pkg::*; (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               last_score,
    input wire logic               valid,
    input wire logic [RANK_W-1:0]  rank,
    input wire logic               last_rank
);

    // Ranks only come out during a rank pass
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy)
        else $error("rank shown while idle");

    // A transaction flagged last starts the rank pass
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_score) |=> busy)
        else $error("set did not close on last score");

    // The final rank ends the pass
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last_rank) |=> !busy)
        else $error("pass continued after final rank");

    // Each rank needs a fresh sweep, so ranks never come back to back
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("ranks on consecutive cycles");

    // A rank is never zero
    a_rank_nz: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (rank != '0))
        else $error("zero rank");

endmodule

bind score_rank_assigner sra_checker u_sra_checker (.*);

`default_nettype wire
